/* src/atwm_pkg.sv */
// Package for the alarm table weekday match unit.
// Types and constants shared by controller, datapath and top level.
package atwm_pkg;

  localparam int unsigned EntryW = 50;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_MATCH  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef struct packed {
    logic [6:0]  repeat_days;
    logic        enabled;
    logic [16:0] off_time;
    logic [5:0]  on_second;
    logic [5:0]  on_minute;
    logic [4:0]  on_hour;
    logic [7:0]  id;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input word
    logic dow_step;  // advance weekday unit
    logic rd;        // issue table read at scan index
    logic scan_inc;  // advance scan index
    logic wr_cmd;    // write captured entry at hit index
    logic wr_app;    // write captured entry at count
    logic shift;     // write read data at scan index - 2
    logic cnt_inc;
    logic cnt_dec;
    logic set_hit;   // latch read data as result
    logic out_load;  // present result
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic scan_end;  // scan index reached count
    logic hit;       // read data matches
    logic full;
    logic dow_done;
  } sts_t;

endpackage

/* src/atwm_weekday.sv */
// Multi-cycle weekday unit: Zeller's congruence with restoring reduction.
// Depends on no other file.
module atwm_weekday (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        step_i,
  input  logic [4:0]  day_i,
  input  logic [3:0]  month_i,
  input  logic [13:0] year_i,
  output logic        done_o,
  output logic [2:0]  dow_o
);
  // year up to 16383+400, c up to 167; f below 2^11
  logic [14:0] y_q, y_d;
  logic [7:0]  c_q, c_d;
  logic [10:0] f_q, f_d;
  logic [4:0]  m_q, m_d;
  logic [4:0]  d_q;
  logic [4:0]  ph_q, ph_d;
  logic        done_q, done_d;
  logic [6:0]  k;
  logic [7:0]  mterm;
  logic [2:0]  dsh, rsh;

  assign k   = 7'(y_q);
  assign dsh = 3'd7 - ph_q[2:0];
  assign rsh = 3'd7 - 3'(ph_q - 5'd9);

  // floor(13 * (m + 1) / 5)
  always_comb begin
    case (m_q)
      5'd0:    mterm = 8'd2;
      5'd1:    mterm = 8'd5;
      5'd2:    mterm = 8'd7;
      5'd3:    mterm = 8'd10;
      5'd4:    mterm = 8'd13;
      5'd5:    mterm = 8'd15;
      5'd6:    mterm = 8'd18;
      5'd7:    mterm = 8'd20;
      5'd8:    mterm = 8'd23;
      5'd9:    mterm = 8'd26;
      5'd10:   mterm = 8'd28;
      5'd11:   mterm = 8'd31;
      5'd12:   mterm = 8'd33;
      5'd13:   mterm = 8'd36;
      5'd14:   mterm = 8'd39;
      5'd15:   mterm = 8'd41;
      default: mterm = 8'd0;
    endcase
  end

  always_comb begin
    y_d = y_q; c_d = c_q; f_d = f_q; m_d = m_q; ph_d = ph_q; done_d = done_q;
    if (start_i) begin
      y_d = 15'(year_i) + 15'd400;
      m_d = {1'b0, month_i};
      if (month_i < 4'd3) begin
        m_d = 5'(month_i) + 5'd12;
        y_d = 15'(year_i) + 15'd399;
      end
      c_d = '0; ph_d = '0; done_d = 1'b0;
    end else if (step_i && !done_q) begin
      case (ph_q)
        5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7: begin
          if (y_q >= (15'd100 << dsh)) begin
            y_d = y_q - (15'd100 << dsh);
            c_d = c_q | (8'd1 << dsh);
          end
          ph_d = ph_q + 5'd1;
        end
        5'd8: begin
          f_d = 11'(d_q) + 11'(mterm) + 11'(k) + 11'(k >> 2) + 11'(c_q >> 2)
              + 11'(c_q) * 11'd5 + 11'd6;
          ph_d = 5'd9;
        end
        default: begin
          if (f_q >= (11'd7 << rsh))
            f_d = f_q - (11'd7 << rsh);
          if (ph_q == 5'd16) done_d = 1'b1;
          ph_d = ph_q + 5'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= '0; done_q <= 1'b0;
    end else begin
      ph_q <= ph_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d; c_q <= c_d; f_q <= f_d; m_q <= m_d;
    if (start_i) d_q <= day_i;
  end

  assign done_o = done_q;
  assign dow_o  = 3'(f_q);
endmodule

/* src/atwm_datapath.sv */
// Datapath: table memory, scan index, count, capture and result registers.
// Depends on atwm_pkg and atwm_weekday.
module atwm_datapath #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  atwm_pkg::ctl_t    ctl_i,
  output atwm_pkg::sts_t    sts_o,
  input  logic [1:0]        cmd_i,
  input  atwm_pkg::entry_t  ent_i,
  input  logic [4:0]        day_i,
  input  logic [3:0]        month_i,
  input  logic [13:0]       year_i,
  output logic [1:0]        status_o,
  output atwm_pkg::entry_t  res_o,
  output logic [2:0]        weekday_o,
  output logic [4:0]        count_o
);
  import atwm_pkg::*;
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  entry_t           mem [TABLE_DEPTH];
  entry_t           rd_q, ent_q, res_q;
  cmd_e             cmd_q;
  logic [CntW-1:0]  cnt_q, idx_q, hidx_q;
  logic [1:0]       stat_q;
  logic [2:0]       wd_q;
  logic             wd_done;
  logic [2:0]       wd;
  logic             hit;

  atwm_weekday u_wd (
    .clk_i, .rst_ni, .start_i(ctl_i.load), .step_i(ctl_i.dow_step),
    .day_i, .month_i, .year_i, .done_o(wd_done), .dow_o(wd)
  );

  always_comb begin
    if (cmd_q == CMD_MATCH)
      hit = rd_q.enabled && rd_q.repeat_days[wd] && rd_q.on_hour == ent_q.on_hour
            && rd_q.on_minute == ent_q.on_minute && rd_q.on_second == ent_q.on_second;
    else
      hit = rd_q.id == ent_q.id;
  end

  assign sts_o = '{cmd: cmd_q, scan_end: idx_q >= cnt_q, hit: hit,
                   full: cnt_q >= CntW'(TABLE_DEPTH), dow_done: wd_done};

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) rd_q <= mem[idx_q[IdxW-1:0]];
    if (ctl_i.wr_cmd) mem[hidx_q[IdxW-1:0]] <= ent_q;
    else if (ctl_i.wr_app) mem[cnt_q[IdxW-1:0]] <= ent_q;
    else if (ctl_i.shift) mem[IdxW'(idx_q - CntW'(2))] <= rd_q;
    if (ctl_i.load) begin
      ent_q <= ent_i;
      cmd_q <= cmd_e'(cmd_i);
    end
    if (ctl_i.set_hit && (cmd_q == CMD_GET || cmd_q == CMD_MATCH)) res_q <= rd_q;
    if (ctl_i.load) res_q <= '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; idx_q <= '0; hidx_q <= '0;
      stat_q <= '0; wd_q <= '0;
    end else begin
      if (ctl_i.load) idx_q <= '0;
      else if (ctl_i.scan_inc) idx_q <= idx_q + CntW'(1);
      if (ctl_i.set_hit) hidx_q <= idx_q - CntW'(1);
      if (ctl_i.cnt_inc) cnt_q <= cnt_q + CntW'(1);
      else if (ctl_i.cnt_dec) cnt_q <= cnt_q - CntW'(1);
      if (ctl_i.out_load) begin
        wd_q <= (cmd_q == CMD_MATCH) ? wd : 3'd0;
        stat_q <= ST_OK;
      end
    end
  end

  // status derived by controller path: found if hidx latched via res flag
  logic found_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) found_q <= 1'b0;
    else if (ctl_i.load) found_q <= 1'b0;
    else if (ctl_i.set_hit) found_q <= 1'b1;
  end
  logic full_add_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_add_q <= 1'b0;
    else if (ctl_i.out_load)
      full_add_q <= cmd_q == CMD_ADD && !found_q && cnt_q >= CntW'(TABLE_DEPTH)
                    && !ctl_i.cnt_inc;
  end
  logic nf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) nf_q <= 1'b0;
    else if (ctl_i.out_load) nf_q <= cmd_q != CMD_ADD && !found_q;
  end

  assign status_o  = full_add_q ? ST_FULL : (nf_q ? ST_NOTFOUND : stat_q);
  assign res_o     = res_q;
  assign weekday_o = wd_q;
  assign count_o   = 5'(cnt_q);
endmodule

/* src/atwm_ctrl.sv */
// Controller state machine: sequences table scans, writes and result hand-off.
// Depends on atwm_pkg.
module atwm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  atwm_pkg::sts_t sts_i,
  output atwm_pkg::ctl_t ctl_o
);
  import atwm_pkg::*;
  typedef enum logic [2:0] {
    S_IDLE, S_DOW, S_READ, S_CHECK, S_SHIFT_RD, S_SHIFT_WR, S_FIN, S_OUT
  } state_e;

  state_e state_q;
  logic   ov_q;
  logic   found_q;

  // command writes and count updates happen in S_OUT, after status is latched
  always_comb begin
    ctl_o = '0;
    ctl_o.dow_step = 1'b1;
    case (state_q)
      S_IDLE:  ctl_o.load = in_valid_i && !ov_q;
      S_READ:  if (!sts_i.scan_end) begin
        ctl_o.rd = 1'b1; ctl_o.scan_inc = 1'b1;
      end
      S_CHECK: if (sts_i.hit) ctl_o.set_hit = 1'b1;
      S_SHIFT_RD: if (!sts_i.scan_end) begin
        ctl_o.rd = 1'b1; ctl_o.scan_inc = 1'b1;
      end
      S_SHIFT_WR: ctl_o.shift = 1'b1;
      S_FIN: ctl_o.out_load = 1'b1;
      S_OUT: begin
        ctl_o.wr_cmd  = sts_i.cmd == CMD_ADD && found_q;
        ctl_o.wr_app  = sts_i.cmd == CMD_ADD && !found_q && !sts_i.full;
        ctl_o.cnt_inc = sts_i.cmd == CMD_ADD && !found_q && !sts_i.full;
        ctl_o.cnt_dec = sts_i.cmd == CMD_DELETE && found_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ov_q <= 1'b0; found_q <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i && !ov_q) begin
          found_q <= 1'b0;
          state_q <= S_DOW;
        end
        S_DOW: if (sts_i.dow_done || sts_i.cmd != CMD_MATCH) state_q <= S_READ;
        S_READ: state_q <= sts_i.scan_end ? S_FIN : S_CHECK;
        S_CHECK: begin
          if (sts_i.hit) begin
            found_q <= 1'b1;
            state_q <= (sts_i.cmd == CMD_DELETE) ? S_SHIFT_RD : S_FIN;
          end else state_q <= S_READ;
        end
        S_SHIFT_RD: state_q <= sts_i.scan_end ? S_FIN : S_SHIFT_WR;
        S_SHIFT_WR: state_q <= S_SHIFT_RD;
        S_FIN: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          ov_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = state_q == S_IDLE && !ov_q;
  assign out_valid_o = ov_q;
endmodule

/* src/alarm_table_weekday_match_unit.sv */
// Alarm table with weekday match: one command word in, one result word out.
// A command passes through the weekday unit (on a match), a table walk that
// reads one entry at a time through one memory read port, and the finish
// states S_FIN and S_OUT; the next word is taken only after the result is taken.
// Reset (rst_ni low, asynchronous) empties the table; entries hold no reset.
module alarm_table_weekday_match_unit #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd, id, hour, minute, second, off_time, enable_flag, repeat_days, day,
  // month, year; 80 bits
  input  logic [79:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, entry_id, entry_on_hour, entry_on_minute, entry_on_second,
  // entry_off_time, entry_enabled, entry_repeat_days, weekday, entry_count
  output logic [63:0]  m_axis_tdata
);
  import atwm_pkg::*;
  ctl_t   ctl;
  sts_t   sts;
  entry_t ent, res;
  logic [1:0] status;
  logic [2:0] wd;
  logic [4:0] cnt;

  assign ent = '{id: s_axis_tdata[9:2], on_hour: s_axis_tdata[14:10],
                 on_minute: s_axis_tdata[20:15], on_second: s_axis_tdata[26:21],
                 off_time: s_axis_tdata[43:27], enabled: s_axis_tdata[44],
                 repeat_days: s_axis_tdata[51:45]};

  atwm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .ctl_o(ctl)
  );

  atwm_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts), .cmd_i(s_axis_tdata[1:0]),
    .ent_i(ent), .day_i(s_axis_tdata[56:52]), .month_i(s_axis_tdata[60:57]),
    .year_i(s_axis_tdata[74:61]), .status_o(status), .res_o(res),
    .weekday_o(wd), .count_o(cnt)
  );

  assign m_axis_tdata = {4'b0, cnt, wd, res.repeat_days, res.enabled, res.off_time,
                         res.on_second, res.on_minute, res.on_hour, res.id, status};
endmodule

/* src/atwm_checker.sv */
// Port-level checker for the alarm table unit, bound to the top level.
// Depends on atwm_pkg and alarm_table_weekday_match_unit ports only.
module atwm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  import atwm_pkg::*;
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken during work");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input open with pending result");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[59:55] <= 5'd16 && m_axis_tdata[1:0] <= ST_FULL)
    else $error("bad count or status");
endmodule

bind alarm_table_weekday_match_unit atwm_checker u_atwm_checker (.*);
